// ===== hw/rtl/ped_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ped_pkg: shared types and constants of the percent escape decoder
// Command format between classifier and emitter, escape phase codes and the
// hex digit decode.
// ---------------------------------------------------------------------------
package ped_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    // pair: emit a literal '%' first, then data
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pair;
    } t_cmd;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ped_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ped_in_if: escaped byte stream channel
// valid/ready handshake carrying one escaped byte and its end flag.
// ---------------------------------------------------------------------------
interface ped_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_end;

    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink (input valid, input in_byte, input in_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ped_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ped_out_if: decoded byte stream channel
// valid/ready handshake carrying one decoded byte and its end flag.
// ---------------------------------------------------------------------------
interface ped_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_end;

    modport source (output valid, output out_byte, output out_end, input ready);
    modport sink (input valid, input out_byte, input out_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/percent_escape_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// percent_escape_decoder: streaming URL percent decoder
// Takes one escaped byte per cycle and emits the decoded byte stream.
// ---------------------------------------------------------------------------
// One input item is taken every cycle while the command queue has room. An
// input that yields a result is written to the command queue when it is
// accepted and from there to the output register. A '%' followed by only one
// byte before the end flag yields two results, a literal '%' and then that
// byte; the command queue of QUEUE_DEPTH entries absorbs the extra result,
// so the input stalls only when the queue fills behind output back pressure
// or such an end flush.
module percent_escape_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    ped_in_if.sink    i_in,
    ped_out_if.source o_out
);

    logic          f_cmd_valid;
    ped_pkg::t_cmd f_cmd;
    logic          q_not_full;
    logic          q_valid;
    ped_pkg::t_cmd q_cmd;
    logic          b_pop;

    ped_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd_ready (q_not_full),
        .o_cmd_valid (f_cmd_valid),
        .o_cmd       (f_cmd)
    );

    ped_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_cmd_valid),
        .i_cmd      (f_cmd),
        .o_not_full (q_not_full),
        .i_pop      (b_pop),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd)
    );

    ped_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (b_pop),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ped_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ped_front: input classifier
// Tracks the escape phase, folds hex digit pairs and issues emit commands.
// ---------------------------------------------------------------------------
module ped_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    ped_in_if.sink            i_in,
    input  wire               i_cmd_ready,
    output logic              o_cmd_valid,
    output ped_pkg::t_cmd     o_cmd
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;

    assign i_in.ready = i_cmd_ready;
    assign accept     = i_in.valid && i_cmd_ready;

    always_comb begin
        n_phase     = r_phase;
        n_held      = r_held;
        o_cmd_valid = 1'b0;
        o_cmd.data  = i_in.in_byte;
        o_cmd.last  = i_in.in_end;
        o_cmd.pair  = 1'b0;
        if (r_phase == ped_pkg::PH_PCT) begin
            if (i_in.in_end) begin
                o_cmd_valid = accept;
                o_cmd.pair  = 1'b1;
                n_phase     = accept ? ped_pkg::PH_IDLE : r_phase;
            end else if (accept) begin
                n_held  = i_in.in_byte;
                n_phase = ped_pkg::PH_DIGIT;
            end
        end else if (r_phase == ped_pkg::PH_DIGIT) begin
            o_cmd_valid = accept;
            o_cmd.data  = {ped_pkg::digit_value(r_held), ped_pkg::digit_value(i_in.in_byte)};
            n_phase     = accept ? ped_pkg::PH_IDLE : r_phase;
        end else begin
            if (i_in.in_byte == ped_pkg::PCT_CHAR && !i_in.in_end) begin
                n_phase = accept ? ped_pkg::PH_PCT : r_phase;
            end else begin
                o_cmd_valid = accept;
                n_phase     = accept ? ped_pkg::PH_IDLE : r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ped_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
        r_held <= n_held;
    end

    a_no_cmd_without_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> accept)
        else $error("command issued without an accepted item");
    a_phase_returns_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.in_end |=> r_phase == ped_pkg::PH_IDLE)
        else $error("escape phase left pending after final byte");
    a_pair_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && o_cmd.pair |-> o_cmd.last)
        else $error("literal pair issued before end of string");

endmodule
`default_nettype wire

// ===== hw/rtl/ped_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ped_queue: command queue
// Small register FIFO decoupling the classifier from the emitter.
// ---------------------------------------------------------------------------
module ped_queue #(
    parameter int DEPTH = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  ped_pkg::t_cmd     i_cmd,
    output logic              o_not_full,
    input  wire               i_pop,
    output logic              o_valid,
    output ped_pkg::t_cmd     o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ped_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_not_full = (r_count != CW'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_cmd      = r_mem[r_rd_ptr];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_not_full |-> !i_push)
        else $error("push into full queue");

endmodule
`default_nettype wire

// ===== hw/rtl/ped_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ped_back: result emitter
// Expands queued commands into decoded bytes behind an output register.
// ---------------------------------------------------------------------------
module ped_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cmd_valid,
    input  ped_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    ped_out_if.source         o_out
);

    logic       r_valid, n_valid;
    logic       r_half, n_half;
    logic [7:0] r_byte, n_byte;
    logic       r_end, n_end;
    logic       load;

    assign load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        n_byte  = r_byte;
        n_end   = r_end;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = i_cmd_valid;
            if (i_cmd_valid) begin
                if (i_cmd.pair && !r_half) begin
                    n_byte = ped_pkg::PCT_CHAR;
                    n_end  = 1'b0;
                    n_half = 1'b1;
                end else begin
                    n_byte = i_cmd.data;
                    n_end  = i_cmd.last;
                    n_half = 1'b0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
        r_byte <= n_byte;
        r_end  <= n_end;
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_end  = r_end;

    a_half_means_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> i_cmd_valid && i_cmd.pair)
        else $error("second half pending without a pair command");
    a_first_half_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_valid && !r_end)
        else $error("literal percent of a pair flagged as end");

endmodule
`default_nettype wire
